// ===== sv/tcfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tcfs_pkg
// Shared types and constants of the timed CAN frame sequencer.
// ----------------------------------------------------------------------------
package tcfs_pkg;

  // default depths of the two frame queues
  localparam int unsigned QueueDepthDefault  = 16;
  localparam int unsigned ScriptDepthDefault = 16;

  // register reset values
  localparam logic [15:0] GapTicksReset    = 16'd200;
  localparam logic [15:0] LingerTicksReset = 16'd20;

  // configuration register indexes
  localparam logic CfgQueueGap = 1'b0;
  localparam logic CfgLinger   = 1'b1;

  // input func codes
  localparam logic [1:0] FuncTick  = 2'd0;
  localparam logic [1:0] FuncPushQ = 2'd1;
  localparam logic [1:0] FuncPushS = 2'd2;

  // longest clamped frame length
  localparam logic [3:0] MaxLen = 4'd8;

  // command kinds carried from front to back
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_PUSH_Q = 2'd1,
    CMD_PUSH_S = 2'd2
  } cmd_kind_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_TX_MODE   = 2'd0,
    KIND_NO_OUTPUT = 2'd1,
    KIND_FRAME     = 2'd2
  } kind_e;

  // back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_EMIT = 2'd2
  } back_state_e;

  // stored frame record
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  bus;
    logic [3:0]  len;
    logic [15:0] delay;
    logic [63:0] data;
  } rec_t;

  // classified command
  typedef struct packed {
    cmd_kind_e kind;
    logic      onroad;
    logic      script_start;
    rec_t      rec;
  } cmd_t;

endpackage

// ===== sv/tcfs_front.sv =====
// ----------------------------------------------------------------------------
// tcfs_front
// Accepts input items, drops unused codes, clamps length and masks payload.
// ----------------------------------------------------------------------------
module tcfs_front (
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [119:0]   s_axis_tdata,
  input  logic [1:0]     s_axis_tuser,
  input  logic           full_i,
  output logic           push_o,
  output tcfs_pkg::cmd_t cmd_o
);
  import tcfs_pkg::*;

  logic [7:0]  len_raw;
  logic [3:0]  len_clamp;
  logic [63:0] payload;
  logic [63:0] data_masked;
  logic        known_code;

  assign s_axis_tready = !full_i;

  // field extraction and length clamp
  assign len_raw   = s_axis_tdata[49:42];
  assign payload   = s_axis_tdata[113:50];
  assign len_clamp = (len_raw > {4'd0, MaxLen}) ? MaxLen : len_raw[3:0];

  // zero bytes at or beyond the clamped length
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      data_masked[8*i +: 8] = (4'(i) < len_clamp) ? payload[8*i +: 8] : 8'd0;
    end
  end

  // classify; code 3 is swallowed
  assign known_code = (s_axis_tuser == FuncTick) || (s_axis_tuser == FuncPushQ) ||
                      (s_axis_tuser == FuncPushS);
  assign push_o = s_axis_tvalid && !full_i && known_code;

  always_comb begin
    cmd_o.kind         = CMD_TICK;
    case (s_axis_tuser)
      FuncPushQ: cmd_o.kind = CMD_PUSH_Q;
      FuncPushS: cmd_o.kind = CMD_PUSH_S;
      default:   cmd_o.kind = CMD_TICK;
    endcase
    cmd_o.onroad       = s_axis_tdata[0];
    cmd_o.script_start = s_axis_tdata[1];
    cmd_o.rec.delay    = s_axis_tdata[17:2];
    cmd_o.rec.id       = s_axis_tdata[33:18];
    cmd_o.rec.bus      = s_axis_tdata[41:34];
    cmd_o.rec.len      = len_clamp;
    cmd_o.rec.data     = data_masked;
  end

endmodule

// ===== sv/tcfs_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// tcfs_cmd_queue
// Two-entry command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module tcfs_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcfs_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output tcfs_pkg::cmd_t cmd_o
);
  import tcfs_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and count update
  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// ===== sv/tcfs_back.sv =====
// ----------------------------------------------------------------------------
// tcfs_back
// Executes commands: owns both frame queues, the timers and the result register.
// ----------------------------------------------------------------------------
module tcfs_back #(
  parameter int unsigned QUEUE_DEPTH  = tcfs_pkg::QueueDepthDefault,
  parameter int unsigned SCRIPT_DEPTH = tcfs_pkg::ScriptDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_index_i,
  input  logic [15:0]    cfg_data_i,
  input  logic           cmd_valid_i,
  input  tcfs_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [95:0]    m_axis_tdata,
  output logic [1:0]     m_axis_tuser,
  output logic           m_axis_tlast
);
  import tcfs_pkg::*;

  localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SAW = (SCRIPT_DEPTH > 1) ? $clog2(SCRIPT_DEPTH) : 1;
  localparam int unsigned SCW = $clog2(SCRIPT_DEPTH + 1);

  back_state_e state_q, state_d;

  // configuration
  logic [15:0] gap_q, linger_q;

  // timers and mode
  logic [31:0] tick_q, tick_d;
  logic [31:0] lqs_q, lqs_d;
  logic [31:0] lss_q, lss_d;
  logic        mode_q, mode_d;

  // queue pointers
  logic [QAW-1:0] qhead_q, qhead_d, qtail_q, qtail_d;
  logic [QCW-1:0] qcnt_q, qcnt_d;
  logic [SAW-1:0] shead_q, shead_d, stail_q, stail_d;
  logic [SCW-1:0] scnt_q, scnt_d;

  // memories and registered head reads
  rec_t           qmem [QUEUE_DEPTH];
  rec_t           smem [SCRIPT_DEPTH];
  rec_t           qrd_q, srd_q;
  logic           qwe, swe;
  logic [SAW-1:0] swaddr;

  // result plan
  logic       plain_q, plain_d;
  logic       ssend_q, ssend_d;
  logic [2:0] nres_q, nres_d;
  logic [1:0] step_q, step_d;
  rec_t       qrec_q, qrec_d, srec_q, srec_d;

  // output register
  logic        out_valid_q, out_valid_d;
  kind_e       out_kind_q, out_kind_d;
  logic        out_last_q, out_last_d;
  rec_t        out_rec_q, out_rec_d;

  // evaluation terms
  logic [31:0] el_q, el_s;
  logic        plain_go, due, lingered, drop_go, send_go;
  logic        load, step_last;
  logic [1:0]  soff;
  kind_e       res_kind;
  rec_t        res_rec;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q    <= GapTicksReset;
      linger_q <= LingerTicksReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgQueueGap: gap_q    <= cfg_data_i;
        CfgLinger:   linger_q <= cfg_data_i;
        default:     gap_q    <= gap_q;
      endcase
    end
  end

  // elapsed-time checks, now is the already advanced tick count
  assign el_q     = tick_q - lqs_q;
  assign el_s     = tick_q - lss_q;
  assign plain_go = (qcnt_q != '0) && (scnt_q == '0) && (el_q >= {16'd0, gap_q});
  assign due      = (scnt_q != '0) && (el_s >= {16'd0, srd_q.delay});
  assign lingered = mode_q && (el_s >= {16'd0, linger_q});
  assign send_go  = due;
  assign drop_go  = !due && lingered;

  // emit sequencing
  assign load      = !out_valid_q || m_axis_tready;
  assign step_last = ({1'b0, step_q} == (nres_q - 3'd1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && cmd_i.kind == CMD_TICK && !cmd_i.onroad) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (plain_go || send_go || drop_go) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (load && step_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // selection of the result at the current step
  always_comb begin
    soff     = plain_q ? (step_q - 2'd3) : step_q;
    res_kind = KIND_NO_OUTPUT;
    res_rec  = '0;
    if (plain_q && step_q < 2'd3) begin
      case (step_q)
        2'd0:    res_kind = KIND_TX_MODE;
        2'd1: begin
          res_kind = KIND_FRAME;
          res_rec  = qrec_q;
        end
        default: res_kind = KIND_NO_OUTPUT;
      endcase
    end else if (ssend_q) begin
      if (soff == 2'd0) begin
        res_kind = KIND_TX_MODE;
      end else begin
        res_kind = KIND_FRAME;
        res_rec  = srec_q;
      end
    end
  end

  // datapath and control outputs
  always_comb begin
    cmd_pop_o   = 1'b0;
    qwe         = 1'b0;
    swe         = 1'b0;
    swaddr      = stail_q;
    tick_d      = tick_q;
    lqs_d       = lqs_q;
    lss_d       = lss_q;
    mode_d      = mode_q;
    qhead_d     = qhead_q;
    qtail_d     = qtail_q;
    qcnt_d      = qcnt_q;
    shead_d     = shead_q;
    stail_d     = stail_q;
    scnt_d      = scnt_q;
    plain_d     = plain_q;
    ssend_d     = ssend_q;
    nres_d      = nres_q;
    step_d      = step_q;
    qrec_d      = qrec_q;
    srec_d      = srec_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    out_rec_d   = out_rec_q;

    case (state_q)
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_PUSH_Q: begin
              if (qcnt_q != QCW'(QUEUE_DEPTH)) begin
                qwe     = 1'b1;
                qtail_d = (qtail_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : qtail_q + 1'b1;
                qcnt_d  = qcnt_q + 1'b1;
              end
            end
            CMD_PUSH_S: begin
              // a new script replaces the pending one
              if (cmd_i.script_start) begin
                swe     = 1'b1;
                swaddr  = '0;
                shead_d = '0;
                stail_d = (SCRIPT_DEPTH == 1) ? '0 : SAW'(1);
                scnt_d  = SCW'(1);
                lss_d   = tick_q;
              end else if (scnt_q != SCW'(SCRIPT_DEPTH)) begin
                swe     = 1'b1;
                stail_d = (stail_q == SAW'(SCRIPT_DEPTH - 1)) ? '0 : stail_q + 1'b1;
                scnt_d  = scnt_q + 1'b1;
              end
            end
            default: begin
              tick_d = tick_q + 32'd1;
              if (cmd_i.onroad) begin
                qhead_d = '0;
                qtail_d = '0;
                qcnt_d  = '0;
                shead_d = '0;
                stail_d = '0;
                scnt_d  = '0;
                mode_d  = 1'b0;
              end
            end
          endcase
        end
      end
      ST_EVAL: begin
        plain_d = plain_go;
        ssend_d = send_go;
        nres_d  = (plain_go ? 3'd3 : 3'd0) + (send_go ? 3'd2 : (drop_go ? 3'd1 : 3'd0));
        step_d  = 2'd0;
        qrec_d  = qrd_q;
        srec_d  = srd_q;
        if (plain_go) begin
          lqs_d   = tick_q;
          qhead_d = (qhead_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : qhead_q + 1'b1;
          qcnt_d  = qcnt_q - 1'b1;
        end
        if (send_go) begin
          lss_d   = tick_q;
          mode_d  = 1'b1;
          shead_d = (shead_q == SAW'(SCRIPT_DEPTH - 1)) ? '0 : shead_q + 1'b1;
          scnt_d  = scnt_q - 1'b1;
        end else if (drop_go) begin
          mode_d = 1'b0;
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_kind_d  = res_kind;
          out_rec_d   = res_rec;
          out_last_d  = step_last;
          step_d      = step_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      lqs_q       <= '0;
      lss_q       <= '0;
      mode_q      <= 1'b0;
      qhead_q     <= '0;
      qtail_q     <= '0;
      qcnt_q      <= '0;
      shead_q     <= '0;
      stail_q     <= '0;
      scnt_q      <= '0;
      plain_q     <= 1'b0;
      ssend_q     <= 1'b0;
      nres_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_TX_MODE;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      lqs_q       <= lqs_d;
      lss_q       <= lss_d;
      mode_q      <= mode_d;
      qhead_q     <= qhead_d;
      qtail_q     <= qtail_d;
      qcnt_q      <= qcnt_d;
      shead_q     <= shead_d;
      stail_q     <= stail_d;
      scnt_q      <= scnt_d;
      plain_q     <= plain_d;
      ssend_q     <= ssend_d;
      nres_q      <= nres_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      out_kind_q  <= out_kind_d;
      out_last_q  <= out_last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    qrec_q    <= qrec_d;
    srec_q    <= srec_d;
    out_rec_q <= out_rec_d;
  end

  // plain queue memory, head read registered
  always_ff @(posedge clk_i) begin
    if (qwe) begin
      qmem[qtail_q] <= cmd_i.rec;
    end
    qrd_q <= qmem[qhead_q];
  end

  // script queue memory, head read registered
  always_ff @(posedge clk_i) begin
    if (swe) begin
      smem[swaddr] <= cmd_i.rec;
    end
    srd_q <= smem[shead_q];
  end

  // result channel
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'd0, out_rec_q.data, out_rec_q.len, out_rec_q.bus, out_rec_q.id};

endmodule

// ===== sv/timed_can_frame_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// timed_can_frame_sequencer_core
// Two frame queues, one paced by a fixed gap and one by per-record delays,
// served on millisecond ticks.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             contents
//  s_axis    in   tvalid/tready         tuser func; tdata records and tick flags
//  m_axis    out  tvalid/tready         tuser kind; tdata frame; tlast end of tick
//  cfg       in   cfg_we_i              cfg_index_i, cfg_data_i
//
//  a push item passes the command queue, then the back-end write
//  an offroad tick goes idle, eval, then emit if it has results (n, 0 to 4,
//  one per cycle from the output register while m_axis is ready); an onroad
//  tick stays in idle; the head reads of both queue memories set the eval step
//  the two-entry command queue takes up to two items while results wait downstream
//  reset clears both queues, all timers and the asserted mode
// ----------------------------------------------------------------------------
module timed_can_frame_sequencer_core #(
  parameter int unsigned QUEUE_DEPTH  = tcfs_pkg::QueueDepthDefault,
  parameter int unsigned SCRIPT_DEPTH = tcfs_pkg::ScriptDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // onroad, script_start, delay[15:0], frame_id[15:0], bus_num[7:0],
  // length_raw[7:0], payload[63:0], zero fill
  input  logic [119:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_id[15:0], out_bus[7:0], out_length[3:0], out_data[63:0], zero fill
  output logic [95:0]  m_axis_tdata,
  // kind[1:0]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import tcfs_pkg::*;

  logic push, full, cmd_valid, cmd_pop;
  cmd_t cmd_in, cmd_out;

  // accept and classify
  tcfs_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  // decoupling queue
  tcfs_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .valid_o (cmd_valid),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_out)
  );

  // execute
  tcfs_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .SCRIPT_DEPTH (SCRIPT_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_out),
    .cmd_pop_o     (cmd_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== tb/sv/tb_timed_can_frame_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// tb_timed_can_frame_sequencer_core
// Self-checking bench for the timed CAN frame sequencer. A queue-fed driver
// and a clocked monitor run directed and random plain pushes, script pushes
// and ticks over several gap and linger settings. A per-item model of both
// frame queues predicts every mode and frame result of each tick.
// ----------------------------------------------------------------------------
module tb_timed_can_frame_sequencer_core;
  import tcfs_pkg::*;

  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned QuietLimit = 4000;

  // one input item
  typedef struct packed {
    logic [1:0]  func;
    logic        onroad;
    logic        script_start;
    logic [15:0] delay;
    logic [15:0] id;
    logic [7:0]  bus;
    logic [7:0]  len_raw;
    logic [63:0] payload;
  } cmd_item_t;

  // one result item
  typedef struct packed {
    kind_e       kind;
    logic [15:0] id;
    logic [7:0]  bus;
    logic [3:0]  len;
    logic [63:0] data;
    logic        last;
  } seq_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_index_i = CfgQueueGap;
  logic [15:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  cmd_item_t cur_cmd = '0;

  // tdata: onroad, script_start, delay, id, bus, len_raw, payload, zero fill
  assign s_axis_tdata = {6'd0, cur_cmd.payload, cur_cmd.len_raw, cur_cmd.bus, cur_cmd.id,
                         cur_cmd.delay, cur_cmd.script_start, cur_cmd.onroad};
  assign s_axis_tuser = cur_cmd.func;

  timed_can_frame_sequencer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  wire in_fire  = s_axis_tvalid && s_axis_tready;
  wire out_fire = m_axis_tvalid && m_axis_tready;

  // stimulus and scoreboard state
  cmd_item_t   pending_cmds[$];
  seq_result_t due_results[$];
  seq_result_t tick_results[$];
  logic        in_taken = 1'b0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;
  int unsigned items_taken = 0;
  int unsigned ticks_taken = 0;
  int unsigned results_seen = 0;
  int unsigned frames_seen = 0;

  // model of the sequencer
  logic [15:0] gap_ticks = GapTicksReset;
  logic [15:0] linger_ticks = LingerTicksReset;
  logic [31:0] tick_now = '0;
  logic [31:0] last_plain_tx = '0;
  logic [31:0] last_script_tx = '0;
  logic        tx_mode_on = 1'b0;
  rec_t        plain_fifo[$];
  rec_t        script_fifo[$];

  // append one item to the stimulus queue
  function automatic void add_cmd(cmd_item_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic cmd_item_t make_cmd(logic [1:0] func, logic onroad, logic start,
                                         logic [15:0] delay, logic [15:0] id,
                                         logic [7:0] bus, logic [7:0] len_raw,
                                         logic [63:0] payload);
    cmd_item_t c;
    c.func = func;
    c.onroad = onroad;
    c.script_start = start;
    c.delay = delay;
    c.id = id;
    c.bus = bus;
    c.len_raw = len_raw;
    c.payload = payload;
    return c;
  endfunction

  // length clamp and masking of bytes past the length
  function automatic rec_t to_record(cmd_item_t c);
    rec_t r;
    logic [63:0] keep;
    r.id = c.id;
    r.bus = c.bus;
    r.delay = c.delay;
    r.len = (c.len_raw > 8'd8) ? MaxLen : c.len_raw[3:0];
    keep = (r.len == MaxLen) ? '1 : ((64'd1 << (8 * r.len)) - 64'd1);
    r.data = c.payload & keep;
    return r;
  endfunction

  function automatic void queue_result(kind_e k, rec_t r);
    seq_result_t x;
    x.kind = k;
    x.id = r.id;
    x.bus = r.bus;
    x.len = r.len;
    x.data = r.data;
    x.last = 1'b0;
    tick_results.insert(tick_results.size(), x);
  endfunction

  // expected results of one accepted item
  function automatic void schedule_frames(cmd_item_t c);
    rec_t r;
    logic [31:0] since;
    tick_results.delete();
    case (c.func)
      FuncPushQ: begin
        if (plain_fifo.size() < QueueDepthDefault)
          plain_fifo.insert(plain_fifo.size(), to_record(c));
      end
      FuncPushS: begin
        if (c.script_start) begin
          script_fifo.delete();
          last_script_tx = tick_now;
        end
        if (script_fifo.size() < ScriptDepthDefault)
          script_fifo.insert(script_fifo.size(), to_record(c));
      end
      FuncTick: begin
        tick_now = tick_now + 32'd1;
        if (c.onroad) begin
          plain_fifo.delete();
          script_fifo.delete();
          tx_mode_on = 1'b0;
        end else begin
          // plain queue, only while no script is pending
          since = tick_now - last_plain_tx;
          if (plain_fifo.size() != 0 && script_fifo.size() == 0 && since >= gap_ticks) begin
            r = plain_fifo.pop_front();
            last_plain_tx = tick_now;
            queue_result(KIND_TX_MODE, '0);
            queue_result(KIND_FRAME, r);
            queue_result(KIND_NO_OUTPUT, '0);
          end
          // script queue, else drop the mode once the linger time ran out
          since = tick_now - last_script_tx;
          if (script_fifo.size() != 0 && since >= script_fifo[0].delay) begin
            r = script_fifo.pop_front();
            last_script_tx = tick_now;
            tx_mode_on = 1'b1;
            queue_result(KIND_TX_MODE, '0);
            queue_result(KIND_FRAME, r);
          end else if (tx_mode_on && since >= linger_ticks) begin
            queue_result(KIND_NO_OUTPUT, '0);
            tx_mode_on = 1'b0;
          end
        end
      end
      default: ;
    endcase
    foreach (tick_results[i]) begin
      tick_results[i].last = (i == tick_results.size() - 1);
      due_results.insert(due_results.size(), tick_results[i]);
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_val,
                                      logic [63:0] act_val);
    if (exp_val !== act_val) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
    end
  endfunction

  // monitor: check results first, then predict the accepted item
  always @(posedge clk_i) begin
    seq_result_t want;
    if (rst_ni) begin
      in_taken = in_fire;
      if (out_fire) begin
        results_seen++;
        if (due_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual kind %0d data %h",
                   $time, m_axis_tuser, m_axis_tdata);
        end else begin
          want = due_results.pop_front();
          if (want.kind == KIND_FRAME) frames_seen++;
          check_field("kind", want.kind, m_axis_tuser);
          check_field("out_id", want.id, m_axis_tdata[15:0]);
          check_field("out_bus", want.bus, m_axis_tdata[23:16]);
          check_field("out_length", want.len, m_axis_tdata[27:24]);
          check_field("out_data", want.data, m_axis_tdata[91:28]);
          check_field("last", want.last, m_axis_tlast);
        end
      end
      if (in_fire) begin
        items_taken++;
        if (cur_cmd.func == FuncTick) ticks_taken++;
        schedule_frames(cur_cmd);
      end
    end
  end

  // driver: next item once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        cur_cmd <= pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, due_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    if (idx == CfgQueueGap) gap_ticks = val;
    else linger_ticks = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until everything sent is taken and every result is back
  task automatic settle();
    while (pending_cmds.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic cmd_item_t random_cmd(logic [1:0] func);
    logic        onroad;
    logic        start;
    logic [15:0] delay;
    logic [7:0]  len_raw;
    onroad = 1'($urandom_range(1));
    start = 1'($urandom_range(1));
    delay = 16'($urandom_range(65535));
    len_raw = ($urandom_range(1) == 0) ? 8'($urandom_range(8)) : 8'($urandom_range(255));
    if (func == FuncTick) onroad = ($urandom_range(99) < 4);
    if (func == FuncPushS) begin
      start = ($urandom_range(99) < 25);
      if ($urandom_range(99) >= 5) delay = 16'($urandom_range(5));
    end
    return make_cmd(func, onroad, start, delay, 16'($urandom_range(65535)),
                    8'($urandom_range(255)), len_raw, {$urandom, $urandom});
  endfunction

  task automatic add_random(input int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 45) add_cmd(random_cmd(FuncTick));
      else if (pick < 70) add_cmd(random_cmd(FuncPushQ));
      else if (pick < 95) add_cmd(random_cmd(FuncPushS));
      else add_cmd(random_cmd(FuncUnused));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct = 38;
    rx_idle_pct = 48;

    // reset register values: plain frame held by the gap, script frame at delay zero
    add_cmd(make_cmd(FuncPushQ, 1'b0, 1'b0, 16'hffff, 16'hffff, 8'hff, 8'hff, '1));
    add_cmd(make_cmd(FuncPushS, 1'b0, 1'b1, 16'd0, 16'h0123, 8'h01, 8'd0, '1));
    add_cmd(make_cmd(FuncTick, 1'b0, 1'b0, '0, '0, '0, '0, '0));
    add_cmd(make_cmd(FuncTick, 1'b0, 1'b0, '0, '0, '0, '0, '0));
    add_cmd(make_cmd(FuncTick, 1'b1, 1'b0, '0, '0, '0, '0, '0));
    settle();

    // zero gap and zero linger
    write_reg(CfgQueueGap, 16'd0);
    write_reg(CfgLinger, 16'd0);
    add_cmd(make_cmd(FuncPushQ, 1'b0, 1'b0, '0, '0, '0, 8'd3, {$urandom, $urandom}));
    add_cmd(make_cmd(FuncPushQ, 1'b0, 1'b0, '0, 16'h8001, 8'h80, 8'd8,
                     {$urandom, $urandom}));
    add_cmd(make_cmd(FuncTick, 1'b0, 1'b0, '0, '0, '0, '0, '0));
    add_cmd(make_cmd(FuncTick, 1'b0, 1'b0, '0, '0, '0, '0, '0));
    // script with a delay holds back a later plain record
    add_cmd(make_cmd(FuncPushS, 1'b0, 1'b1, 16'd2, 16'h5a5a, 8'h3c, 8'd9,
                     {$urandom, $urandom}));
    add_cmd(make_cmd(FuncPushS, 1'b0, 1'b0, 16'd0, 16'ha5a5, 8'hc3, 8'd1,
                     {$urandom, $urandom}));
    add_cmd(make_cmd(FuncPushQ, 1'b0, 1'b0, '0, 16'h0777, 8'h07, 8'd5,
                     {$urandom, $urandom}));
    repeat (4) add_cmd(make_cmd(FuncTick, 1'b0, 1'b0, '0, '0, '0, '0, '0));
    // unused func code is ignored
    add_cmd(make_cmd(FuncUnused, 1'b1, 1'b1, '1, '1, '1, '1, '1));
    // longest delay, then a new script replaces it
    add_cmd(make_cmd(FuncPushS, 1'b0, 1'b1, 16'hffff, 16'h1111, 8'h11, 8'd4,
                     {$urandom, $urandom}));
    add_cmd(make_cmd(FuncTick, 1'b0, 1'b0, '0, '0, '0, '0, '0));
    add_cmd(make_cmd(FuncPushS, 1'b0, 1'b0, 16'd0, 16'h2222, 8'h22, 8'd2,
                     {$urandom, $urandom}));
    add_cmd(make_cmd(FuncPushS, 1'b0, 1'b1, 16'd0, 16'h3333, 8'h33, 8'd7,
                     {$urandom, $urandom}));
    add_cmd(make_cmd(FuncTick, 1'b0, 1'b0, '0, '0, '0, '0, '0));
    add_cmd(make_cmd(FuncTick, 1'b0, 1'b0, '0, '0, '0, '0, '0));
    // onroad tick drops a pending plain record
    add_cmd(make_cmd(FuncPushQ, 1'b0, 1'b0, '0, 16'h4444, 8'h44, 8'd6,
                     {$urandom, $urandom}));
    add_cmd(make_cmd(FuncTick, 1'b1, 1'b0, '0, '0, '0, '0, '0));
    add_cmd(make_cmd(FuncTick, 1'b0, 1'b0, '0, '0, '0, '0, '0));
    settle();

    // random traffic, receiver-heavy idling
    write_reg(CfgQueueGap, 16'd2);
    write_reg(CfgLinger, 16'd3);
    add_random(8);
    settle();

    // random traffic, sender-heavy idling
    tx_idle_pct = 48;
    rx_idle_pct = 38;
    write_reg(CfgQueueGap, 16'd5);
    write_reg(CfgLinger, 16'hffff);
    add_random(8);
    settle();

    // random traffic, no idling, plain queue effectively blocked by the gap
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CfgQueueGap, 16'hffff);
    write_reg(CfgLinger, 16'd1);
    add_random(8);
    settle();

    // both queues overfilled, then ticks against a long receiver hold-off
    write_reg(CfgQueueGap, 16'd1);
    write_reg(CfgLinger, 16'd0);
    repeat (17) add_cmd(random_cmd(FuncPushQ));
    for (int i = 0; i < 17; i++)
      add_cmd(make_cmd(FuncPushS, 1'b0, (i == 0), 16'($urandom_range(1)),
                       16'($urandom_range(65535)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), {$urandom, $urandom}));
    repeat (16) add_cmd(make_cmd(FuncTick, 1'b0, 1'b0, '0, '0, '0, '0, '0));
    hold_asked++;
    settle();

    $display("run covered %0d items (%0d ticks) over six register settings", items_taken,
             ticks_taken);
    $display("checked %0d results, %0d of them frames, %0d errors", results_seen,
             frames_seen, error_count);
    if (error_count == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tcfs_pkg.sv
sv/tcfs_front.sv
sv/tcfs_cmd_queue.sv
sv/tcfs_back.sv
sv/timed_can_frame_sequencer_core.sv
tb/sv/tb_timed_can_frame_sequencer_core.sv
